/* rtl/bsa_pkg.sv */
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

  // Field widths
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int WIU_W = 5;

  // Largest number of words the words_in_use register can name
  localparam int MAX_ACTIVE = (1 << WIU_W) - 1;

  // Configuration register reset value
  localparam logic [WIU_W-1:0] WIU_RESET = 5'd16;

  // Configuration port address width and register index
  localparam int PADDR_W = 3;
  localparam logic REG_WORDS_IN_USE = 1'b0;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] used_count;
  } rsp_t;

endpackage

/* rtl/bsa_stream_ifs.sv */
// Request and response stream interfaces of the bitmap slot allocator.
interface bsa_req_if;
  import bsa_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/bitmap_slot_allocator_top.sv */
// Bitmap slot allocator: sequencer, bitmap memory, output register and APB register.
//
//   Channel   Dir   Handshake          Payload
//   req       in    valid/ready        command, free_index
//   rsp       out   valid/ready        status, granted_index, used_count
//   apb       in    psel/penable       words_in_use at byte address 0
//
// Allocate: tests the hinted word first; on a hint miss the downward scan probes
// one word at a time from the highest word in use, through the single bitmap read port.
// Free: S_MUL and S_DIV split the index into word and bit by reciprocal multiply.
// Reset: clears the per-word valid flags; no clearing pass over the bitmap.
// A new transaction is taken while a result waits in the output register; the
// next result holds in its final step until that register is free.
module bitmap_slot_allocator_top #(
  parameter int WORD_BITS = 64,
  parameter int NUM_WORDS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  bsa_req_if.sink                      req,
  bsa_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bsa_pkg::*;

  localparam int ACT_MAX     = (NUM_WORDS > MAX_ACTIVE) ? MAX_ACTIVE : NUM_WORDS;
  localparam int AW          = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1;
  localparam int BW          = $clog2(WORD_BITS);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS + 1;
  localparam int RW          = $clog2(RECIP + 1);
  localparam int PW          = IDX_W + RW;
  localparam int GW          = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FCHK
  } state_t;

  state_t state, state_next;

  logic [WIU_W-1:0]     words_in_use;
  logic [AW-1:0]        hint_word, hint_next;
  logic [AW-1:0]        cur_w, cur_w_next;
  logic [CNT_W-1:0]     slot_count, count_next;
  logic                 scanning, scanning_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [PW-1:0]        prod, prod_next;
  logic [IDX_W-1:0]     qd, qd_next;
  logic                 q_ok, q_ok_next;

  logic [WORD_BITS-1:0] used_map [ACT_MAX];
  logic [ACT_MAX-1:0]   map_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;

  logic                 out_valid;
  logic [1:0]           out_status;
  logic [IDX_W-1:0]     out_granted;
  logic [CNT_W-1:0]     out_count;

  logic [WIU_W-1:0]     nw;
  logic [WORD_BITS-1:0] word;
  logic                 full;
  logic                 hit;
  logic [BW-1:0]        lz;
  logic                 out_free;
  logic [IDX_W-1:0]     q;
  logic [IDX_W-1:0]     rem;
  logic [BW-1:0]        bsel;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 finish;
  logic [1:0]           fin_status;
  logic [IDX_W-1:0]     fin_granted;

  function automatic logic [BW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] b;
    b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) b = BW'(i);
    end
    return b;
  endfunction

  // Clamp the word count to what the memory holds
  assign nw = (words_in_use > WIU_W'(ACT_MAX)) ? WIU_W'(ACT_MAX) : words_in_use;

  // Word under test; a never-written word reads as all free
  assign word     = rd_valid ? rd_data : '0;
  assign full     = &word;
  assign hit      = !full && (WIU_W'(cur_w) < nw);
  assign lz       = lowest_zero(word);
  assign out_free = !out_valid || rsp.ready;

  // Split the free index into word and bit
  assign q        = IDX_W'(prod >> RECIP_SHIFT);
  assign rem      = idx - qd;
  assign bsel     = BW'(rem);
  assign bit_mask = WORD_BITS'(1) << bsel;

  assign req.ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next    = state;
    cur_w_next    = cur_w;
    hint_next     = hint_word;
    count_next    = slot_count;
    scanning_next = scanning;
    idx_next      = idx;
    prod_next     = prod;
    qd_next       = qd;
    q_ok_next     = q_ok;
    wr_en         = 1'b0;
    wr_data       = word;
    finish        = 1'b0;
    fin_status    = ST_OK;
    fin_granted   = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          idx_next = req.data.free_index;
          if (req.data.command == CMD_ALLOC) begin
            state_next = S_CHECK;
            if (WIU_W'(hint_word) < nw) begin
              cur_w_next    = hint_word;
              scanning_next = 1'b0;
            end else begin
              cur_w_next    = (nw != '0) ? AW'(nw - 5'd1) : '0;
              scanning_next = 1'b1;
            end
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_CHECK: begin
        if (hit) begin
          if (out_free) begin
            wr_en       = 1'b1;
            wr_data     = word | (WORD_BITS'(1) << lz);
            count_next  = slot_count + 1'b1;
            hint_next   = cur_w;
            finish      = 1'b1;
            fin_status  = ST_OK;
            fin_granted = IDX_W'(GW'(cur_w) * GW'(WORD_BITS) + GW'(lz));
            state_next  = S_IDLE;
          end
        end else if (!scanning) begin
          scanning_next = 1'b1;
          cur_w_next    = AW'(nw - 5'd1);
        end else if (cur_w == '0) begin
          if (out_free) begin
            finish     = 1'b1;
            fin_status = ST_FULL;
            state_next = S_IDLE;
          end
        end else begin
          cur_w_next = cur_w - 1'b1;
        end
      end
      S_MUL: begin
        prod_next  = PW'(idx) * PW'(RECIP);
        state_next = S_DIV;
      end
      S_DIV: begin
        qd_next    = IDX_W'(GW'(q) * GW'(WORD_BITS));
        q_ok_next  = q < IDX_W'(nw);
        cur_w_next = (q < IDX_W'(nw)) ? AW'(q) : '0;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (q_ok && word[bsel]) begin
            wr_en      = 1'b1;
            wr_data    = word & ~bit_mask;
            count_next = slot_count - 1'b1;
            fin_status = ST_OK;
          end else begin
            fin_status = ST_BADFREE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, control registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hint_word    <= '0;
      cur_w        <= '0;
      slot_count   <= '0;
      scanning     <= 1'b0;
      map_valid    <= '0;
      out_valid    <= 1'b0;
      words_in_use <= WIU_RESET;
    end else begin
      state      <= state_next;
      hint_word  <= hint_next;
      cur_w      <= cur_w_next;
      slot_count <= count_next;
      scanning   <= scanning_next;
      if (wr_en) map_valid[cur_w] <= 1'b1;
      if (finish) begin
        out_valid   <= 1'b1;
        out_status  <= fin_status;
        out_granted <= fin_granted;
        out_count   <= count_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready && (paddr[2] == REG_WORDS_IN_USE)) begin
        words_in_use <= pwdata[WIU_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    prod <= prod_next;
    qd   <= qd_next;
    q_ok <= q_ok_next;
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) used_map[cur_w] <= wr_data;
    rd_data  <= used_map[cur_w_next];
    rd_valid <= map_valid[cur_w_next];
  end

  assign rsp.valid              = out_valid;
  assign rsp.data.status        = out_status;
  assign rsp.data.granted_index = out_granted;
  assign rsp.data.used_count    = out_count;

  // APB read and ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WORDS_IN_USE) ? 32'(words_in_use) : '0;

`ifndef SYNTHESIS
  // Each bitmap write flips exactly one slot
  a_one_bit_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $countones(wr_data ^ word) == 1)
    else $error("bitmap write changes other than one bit");

  // The slot count moves only together with a bitmap write
  a_count_with_write: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && slot_count != $past(slot_count)) |-> $past(wr_en))
    else $error("slot count changed without a bitmap write");

  // Writes happen only in a final step with room in the output register
  a_write_at_finish: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_CHECK || state == S_FCHK) && out_free && finish))
    else $error("bitmap write outside a finishing step");

  // An out-of-slots result grants nothing
  a_full_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status == ST_FULL) |-> rsp.data.granted_index == '0)
    else $error("out-of-slots result carries a granted index");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the bitmap slot allocator top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int SLOT_BITS   = 64;
  localparam int WORDS       = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 112;

  // Tracks the slot pool and queues the response each accepted request should produce
  class slot_pool_scoreboard;
    bit [SLOT_BITS-1:0] used_map [WORDS];
    bit [3:0]           hint_word;
    bit [CNT_W-1:0]     slot_count;
    bit [WIU_W-1:0]     words_in_use;
    rsp_t               expected_rsp_q [$];
    int                 errors;

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      hint_word    = '0;
      slot_count   = '0;
      words_in_use = WIU_RESET;
      errors       = 0;
    endfunction

    function void set_words(bit [WIU_W-1:0] value);
      words_in_use = value;
    endfunction

    function int active_words();
      return (words_in_use > WORDS) ? WORDS : int'(words_in_use);
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction

    // Set the lowest free bit of a word, move the hint there, return the slot
    function bit [IDX_W-1:0] take_slot(int w);
      int b;
      b = 0;
      while (used_map[w][b]) b++;
      used_map[w][b] = 1'b1;
      slot_count++;
      hint_word = w[3:0];
      return IDX_W'(w * SLOT_BITS + b);
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   nw;
      int   wi;
      int   bi;
      e  = '0;
      nw = active_words();
      e.status = ST_OK;
      if (r.command == CMD_ALLOC) begin
        if (hint_word < nw && !(&used_map[hint_word])) begin
          e.granted_index = take_slot(hint_word);
        end else begin
          // Scan downward from the highest word in use
          e.status = ST_FULL;
          for (int w = nw - 1; w >= 0; w--) begin
            if (!(&used_map[w])) begin
              e.granted_index = take_slot(w);
              e.status = ST_OK;
              break;
            end
          end
        end
      end else if (int'(r.free_index) >= nw * SLOT_BITS) begin
        e.status = ST_BADFREE;
      end else begin
        wi = r.free_index / SLOT_BITS;
        bi = r.free_index % SLOT_BITS;
        if (!used_map[wi][bi]) begin
          e.status = ST_BADFREE;
        end else begin
          used_map[wi][bi] = 1'b0;
          slot_count--;
        end
      end
      e.used_count = slot_count;
      expected_rsp_q.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected response: status %0d granted %0d count %0d",
               got.status, got.granted_index, got.used_count);
        errors++;
        return;
      end
      e = expected_rsp_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.granted_index !== e.granted_index) begin
        $error("granted_index: expected %0d, got %0d", e.granted_index, got.granted_index);
        errors++;
      end
      if (got.used_count !== e.used_count) begin
        $error("used_count: expected %0d, got %0d", e.used_count, got.used_count);
        errors++;
      end
    endfunction

    // Pick a random slot in use below the capacity, or -1 if there is none
    function int used_slot();
      int cap;
      int start;
      int s;
      cap = active_words() * SLOT_BITS;
      if (cap == 0) return -1;
      start = $urandom_range(0, cap - 1);
      for (int k = 0; k < cap; k++) begin
        s = (start + k) % cap;
        if (used_map[s / SLOT_BITS][s % SLOT_BITS]) return s;
      end
      return -1;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bsa_req_if req_ch();
  bsa_rsp_if rsp_ch();

  slot_pool_scoreboard sb;

  bit gaps_on;
  bit hold_off_req;
  int burst_left;
  int idle_cycles;

  bitmap_slot_allocator_top #(
    .WORD_BITS(SLOT_BITS),
    .NUM_WORDS(WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Note accepted requests and check accepted responses
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** bitmap_slot_allocator_top: FAILED **");
        $finish;
      end
    end
  end

  // Response backpressure: switch between patterns, with one long hold-off on request
  initial begin
    int mode;
    int seg;
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 64);
      while (seg > 0 && (held || !hold_off_req)) begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
        seg--;
        @(negedge clk);
      end
      if (hold_off_req && !held) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted; gaps between bursts if gaps_on
  task automatic send_request(logic cmd, logic [IDX_W-1:0] idx);
    req_t r;
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r.command    = cmd;
    r.free_index = idx;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write of words_in_use: setup cycle, then access cycle
  task automatic write_words(bit [WIU_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_WORDS_IN_USE) << 2;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_words(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_request(int alloc_pct);
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    int                s;
    cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
    idx = IDX_W'($urandom_range(0, 1023));
    if (cmd == CMD_FREE && $urandom_range(0, 99) < 85) begin
      s = sb.used_slot();
      if (s >= 0) idx = s[IDX_W-1:0];
    end
    send_request(cmd, idx);
  endtask

  initial begin
    int phase_words [12];
    int fill_pct;
    phase_words  = '{1, 2, 16, 1, 0, 31, 3, 12, 2, 1, 16, 5};
    sb           = new();
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    burst_left   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset width, grants, double free, free of an unused slot
    send_request(CMD_ALLOC, 10'd1023);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd5);
    send_request(CMD_FREE, 10'd1);
    send_request(CMD_FREE, 10'd1);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd1023);
    send_request(CMD_FREE, 10'd0);
    drain();
    // Zero words: no capacity at all
    write_words(5'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd0);
    drain();
    // Too many words: clamps to the full pool
    write_words(5'd31);
    send_request(CMD_ALLOC, 10'd512);
    send_request(CMD_FREE, 10'd1023);
    send_request(CMD_FREE, 10'd2);
    drain();
    // One word: indexes at or above 64 are out of range
    write_words(5'd1);
    send_request(CMD_FREE, 10'd64);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd63);
    drain();

    // Random phases: fill, then drain, at a range of pool sizes
    for (int p = 0; p < 12; p++) begin
      write_words(phase_words[p][WIU_W-1:0]);
      gaps_on  = (p % 3 != 0);
      fill_pct = $urandom_range(60, 90);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 30) hold_off_req = 1'b1;
        random_request((n < 70) ? fill_pct : 100 - fill_pct);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** bitmap_slot_allocator_top: PASSED **");
    end else begin
      $display("** bitmap_slot_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bsa_pkg.sv
rtl/bsa_stream_ifs.sv
rtl/bitmap_slot_allocator_top.sv
tb/tb.sv
